[rtl/core/spi_flash_ring_page_writer_core_defines.svh]
// Assertion macros shared by the serial flash ring page writer RTL.
`ifndef SPI_FLASH_RING_PAGE_WRITER_CORE_DEFINES_SVH
`define SPI_FLASH_RING_PAGE_WRITER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define SFRPW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define SFRPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFRPW_ASSERT_SAME(lbl, ante, cons, msg)
`define SFRPW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/sfrpw_pkg.sv]
// Types, command codes and helpers of the serial flash ring page writer.
`default_nettype none

package sfrpw_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_RING_START = 2'd0,
    CFG_RING_STOP  = 2'd1,
    CFG_ERASE_EN   = 2'd2
  } cfg_idx_e;

  // Flash command bytes.
  localparam logic [7:0] CMD_NONE  = 8'h00;
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_PP    = 8'h02;
  localparam logic [7:0] CMD_SE4K  = 8'h20;
  localparam logic [7:0] CMD_SE64K = 8'hD8;

  // Erase geometry.
  localparam logic [31:0] SMALL_SECTOR_END = 32'h0000_8000;
  localparam logic [31:0] BIG_SECTOR_START = 32'h0001_0000;
  localparam logic [31:0] MASK_4K          = 32'h0000_0FFF;
  localparam logic [31:0] MASK_64K         = 32'h0000_FFFF;

  // Last position inside an erase or program header group.
  localparam logic [2:0] POS_LAST = 3'd4;

  // Erase command for a sector that starts at this address, CMD_NONE if none.
  // The region between the small and the big sectors is never erased.
  function automatic logic [7:0] erase_cmd(input logic [31:0] addr);
    logic [7:0] cmd;
    cmd = CMD_NONE;
    if (addr < SMALL_SECTOR_END) begin
      if ((addr & MASK_4K) == 32'd0) cmd = CMD_SE4K;
    end else if (addr >= BIG_SECTOR_START) begin
      if ((addr & MASK_64K) == 32'd0) cmd = CMD_SE64K;
    end
    return cmd;
  endfunction

endpackage

`default_nettype wire

[rtl/core/spi_flash_ring_page_writer_core.sv]
// Serial flash ring page writer: turns data bytes into SPI command and data words.
// The first output word is valid in the cycle after its input word is accepted. Throughput:
// one input word per cycle inside a burst if unstalled; a word that also opens a burst or
// triggers erases drains 6 to 16 output words, one per cycle, from the output register.
// The next input word is accepted in the cycle the last output word of the previous one goes.
// Reset clears the write pointer, address and burst count and loads the register defaults.
`default_nettype none

`include "spi_flash_ring_page_writer_core_defines.svh"

module spi_flash_ring_page_writer_core #(
  parameter int PAGE_BYTES   = 256,  // power of two
  parameter int ADDRESS_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic [23:0] bytes_left_i,
  input  logic        block_first_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  spi_byte_o,
  output logic        release_cs_o,
  output logic        poll_busy_first_o,
  output logic        run_last_o
);
  import sfrpw_pkg::*;

  // Groups of output words that one input word can cause, in emission order.
  typedef enum logic [1:0] {
    SEG_PRE  = 2'd0,
    SEG_HDR  = 2'd1,
    SEG_DATA = 2'd2,
    SEG_POST = 2'd3
  } seg_e;

  localparam int AW       = (ADDRESS_BITS > 24) ? ADDRESS_BITS : 24;
  localparam int PageBits = $clog2(PAGE_BYTES);
  localparam int BW       = $clog2(PAGE_BYTES + 1);
  localparam logic [AW-1:0] AddrMask = AW'((64'd1 << ADDRESS_BITS) - 64'd1);
  localparam logic [BW-1:0] PageLen  = BW'(PAGE_BYTES);

  // Configuration registers.
  logic [23:0] ring_start_q, ring_stop_q;
  logic        erase_en_q;

  // Write state.
  logic [AW-1:0] wp_q, cur_q;
  logic [BW-1:0] burst_q;

  // Output register and drain sequencer.
  logic          out_valid_q, out_valid_d;
  seg_e          seg_q, seg_d;
  logic [2:0]    pos_q, pos_d;
  logic [7:0]    pre_cmd_q, post_cmd_q, data_q;
  logic          hdr_q, rel_q;
  logic [23:0]   addr0_q, addr1_q;

  // Next-state logic.
  logic          in_acc, out_fire, last;
  logic          open_burst, close_burst;
  logic [AW-1:0] wp_masked, start_x, stop_x, cur_a, cur_inc, cur_wrap, cur_d, space;
  logic [23:0]   left_x;
  logic [PageBits-1:0] want, page_lim;
  logic [BW-1:0] count, burst_cur, burst_nx;
  logic [7:0]    pre_cmd_d, post_cmd_d;
  seg_e          seg_start;

  assign cfg_ready_o = 1'b1;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_start_q <= 24'd0;
      ring_stop_q  <= 24'hFF_FFFF;
      erase_en_q   <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RING_START: ring_start_q <= cfg_data_i;
        CFG_RING_STOP:  ring_stop_q  <= cfg_data_i;
        CFG_ERASE_EN:   erase_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Address, burst length and erase decisions for the incoming word.
  always_comb begin
    wp_masked = wp_q & AddrMask;
    start_x   = AW'(ring_start_q);
    stop_x    = AW'(ring_stop_q);
    if (block_first_i) begin
      cur_a = (wp_masked < start_x) ? start_x : wp_masked;
    end else begin
      cur_a = cur_q;
    end
    open_burst = block_first_i || (burst_q == '0);

    // Burst length: block remainder, page remainder and ring space.
    left_x = (bytes_left_i == 24'd0) ? 24'd1 : bytes_left_i;
    if (left_x >= 24'(PAGE_BYTES)) begin
      want = {PageBits{1'b1}};
    end else begin
      want = PageBits'(left_x - 24'd1);
    end
    page_lim = ~cur_a[PageBits-1:0];
    if (want > page_lim) want = page_lim;
    space = (stop_x - cur_a) & AddrMask;
    count = (space >= AW'(PAGE_BYTES)) ? (BW'(want) + BW'(1)) : BW'(1);

    burst_cur   = open_burst ? count : burst_q;
    burst_nx    = burst_cur - BW'(1);
    close_burst = (burst_nx == '0);

    // Address after this byte, wrapping to the ring start when the burst ends past the stop.
    cur_inc  = (cur_a + AW'(1)) & AddrMask;
    cur_wrap = (cur_inc > stop_x) ? start_x : cur_inc;
    cur_d    = close_burst ? cur_wrap : cur_inc;

    pre_cmd_d  = (erase_en_q && block_first_i) ? erase_cmd(32'(cur_a)) : CMD_NONE;
    post_cmd_d = (erase_en_q && close_burst) ? erase_cmd(32'(cur_wrap)) : CMD_NONE;

    if (pre_cmd_d != CMD_NONE) begin
      seg_start = SEG_PRE;
    end else if (open_burst) begin
      seg_start = SEG_HDR;
    end else begin
      seg_start = SEG_DATA;
    end
  end

  // Handshakes: a new word enters when the output register is empty or drains this cycle.
  assign last       = ((seg_q == SEG_DATA) && (post_cmd_q == CMD_NONE)) ||
                      ((seg_q == SEG_POST) && (pos_q == POS_LAST));
  assign out_fire   = out_valid_q && !out_stall_i;
  assign in_stall_o = out_valid_q && !(last && !out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Drain sequencer over the groups of the current word.
  always_comb begin
    out_valid_d = out_valid_q;
    seg_d       = seg_q;
    pos_d       = pos_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
      seg_d       = seg_start;
      pos_d       = 3'd0;
    end else if (out_fire) begin
      if (last) begin
        out_valid_d = 1'b0;
      end else if ((seg_q == SEG_DATA) || (pos_q == POS_LAST)) begin
        pos_d = 3'd0;
        case (seg_q)
          SEG_PRE:  seg_d = hdr_q ? SEG_HDR : SEG_DATA;
          SEG_HDR:  seg_d = SEG_DATA;
          SEG_DATA: seg_d = SEG_POST;
          default:  seg_d = SEG_POST;
        endcase
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end
  end

  // Control state and output payload register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      cur_q       <= '0;
      burst_q     <= '0;
      out_valid_q <= 1'b0;
      seg_q       <= SEG_DATA;
      pos_q       <= 3'd0;
      pre_cmd_q   <= CMD_NONE;
      post_cmd_q  <= CMD_NONE;
      hdr_q       <= 1'b0;
      addr0_q     <= '0;
      addr1_q     <= '0;
      data_q      <= '0;
      rel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      seg_q       <= seg_d;
      pos_q       <= pos_d;
      if (in_acc) begin
        cur_q      <= cur_d;
        burst_q    <= burst_nx;
        if (close_burst) wp_q <= cur_wrap;
        pre_cmd_q  <= pre_cmd_d;
        post_cmd_q <= post_cmd_d;
        hdr_q      <= open_burst;
        addr0_q    <= cur_a[23:0];
        addr1_q    <= cur_wrap[23:0];
        data_q     <= data_byte_i;
        rel_q      <= close_burst;
      end
    end
  end

  // Output word of the current group position.
  always_comb begin
    logic [7:0]  cmd;
    logic [23:0] addr;
    cmd  = (seg_q == SEG_POST) ? post_cmd_q : pre_cmd_q;
    addr = (seg_q == SEG_POST) ? addr1_q : addr0_q;
    if (seg_q == SEG_HDR) cmd = CMD_PP;
    spi_byte_o        = data_q;
    release_cs_o      = 1'b0;
    poll_busy_first_o = 1'b0;
    if (seg_q == SEG_DATA) begin
      release_cs_o = rel_q;
    end else begin
      case (pos_q)
        3'd0: begin
          spi_byte_o        = CMD_WREN;
          release_cs_o      = 1'b1;
          poll_busy_first_o = 1'b1;
        end
        3'd1: spi_byte_o = cmd;
        3'd2: spi_byte_o = addr[23:16];
        3'd3: spi_byte_o = addr[15:8];
        3'd4: begin
          spi_byte_o   = addr[7:0];
          release_cs_o = (seg_q != SEG_HDR);
        end
        default: spi_byte_o = data_q;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign run_last_o  = last;

  // Checks on the drain sequencer and the burst counter.
  `SFRPW_ASSERT_SAME(a_stall_mid_run, out_valid_o && !run_last_o, in_stall_o, "input taken mid run")
  `SFRPW_ASSERT_NEXT(a_drain_empty, out_fire && last && !in_acc, !out_valid_o, "stale output word")
  `SFRPW_ASSERT_SAME(a_burst_range, 1'b1, burst_q <= PageLen, "burst count beyond page")
  `SFRPW_ASSERT_NEXT(a_load_valid, in_acc, out_valid_o && pos_q == 3'd0, "load did not start run")

endmodule

`default_nettype wire
